FILE: rtl/tagged_message_table_drop_oldest_macros.svh
// Assertion macros for the tagged message table.
`ifndef TAGGED_MESSAGE_TABLE_DROP_OLDEST_MACROS_SVH
`define TAGGED_MESSAGE_TABLE_DROP_OLDEST_MACROS_SVH
`define TMT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/tmt_pkg.sv
// Shared types and constants for the tagged message table.
`default_nettype none
package tmt_pkg;
   localparam int TableDepthDefault = 64;
   localparam int PayloadBitsDefault = 32;
   localparam int IdW = 32;
   localparam int StatusW = 4;
   localparam int PosW = 6;
   localparam int OpW = 3;
   localparam int QueueDepth = 2;

   localparam logic [OpW-1:0] OP_ADD = 3'd0;
   localparam logic [OpW-1:0] OP_GET = 3'd1;
   localparam logic [OpW-1:0] OP_MARK = 3'd2;
   localparam logic [OpW-1:0] OP_DEL = 3'd3;
   localparam logic [OpW-1:0] OP_CLEAR = 3'd4;

   localparam logic CSR_UNREAD = 1'b0;
   localparam logic CSR_READ = 1'b1;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0, CMD_GET = 3'd1, CMD_MARK = 3'd2, CMD_DEL = 3'd3,
      CMD_CLEAR = 3'd4, CMD_BAD = 3'd5
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic box;
      logic [63:0] payload;
      logic [StatusW-1:0] status;
      logic [PosW-1:0] position;
      logic [IdW-1:0] key;
   } job_type;
endpackage
`default_nettype wire

FILE: rtl/tmt_front.sv
// Front end: accepts requests, decodes them and queues them for the engine.
`default_nettype none
module tmt_front
   import tmt_pkg::*;
#(
   parameter int PAYLOAD_BITS = PayloadBitsDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [OpW-1:0] req_op,
   input wire logic req_box,
   input wire logic [31:0] req_payload,
   input wire logic [StatusW-1:0] req_status,
   input wire logic [PosW-1:0] req_position,
   input wire logic [IdW-1:0] req_key,
   output logic job_valid,
   input wire logic job_ready,
   output job_type job
);
   job_type q_ff [QueueDepth];
   logic [0:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   job_type dec;
   logic push, pop;
   logic [63:0] pmask;

   always_comb begin
      pmask = '0;
      for (int i = 0; i < 64; i++) begin
         if (i < PAYLOAD_BITS) pmask[i] = 1'b1;
      end
      dec.box = req_box;
      dec.payload = {32'd0, req_payload} & pmask;
      dec.status = req_status;
      dec.position = req_position;
      dec.key = req_key;
      case (req_op)
         OP_ADD: dec.cmd = CMD_ADD;
         OP_GET: dec.cmd = CMD_GET;
         OP_MARK: dec.cmd = CMD_MARK;
         OP_DEL: dec.cmd = CMD_DEL;
         OP_CLEAR: dec.cmd = CMD_CLEAR;
         default: dec.cmd = CMD_BAD;
      endcase
   end

   assign req_tready = cnt_ff != 2'(QueueDepth);
   assign push = req_tvalid && req_tready;
   assign job_valid = cnt_ff != 2'd0;
   assign pop = job_valid && job_ready;
   assign job = q_ff[rd_ff];
   assign wr_in = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in = pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= dec;
   end
endmodule
`default_nettype wire

FILE: rtl/tmt_engine.sv
// Back end: table memories and the sequencer that walks them.
`default_nettype none
module tmt_engine
   import tmt_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int PAYLOAD_BITS = PayloadBitsDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic job_valid,
   output logic job_ready,
   input job_type job,
   input wire logic [StatusW-1:0] unread_code,
   input wire logic [StatusW-1:0] read_code,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [103:0] rsp_tdata
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = IdW + PAYLOAD_BITS + StatusW;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001, S_SRCH = 7'b0000010, S_SCMP = 7'b0000100,
      S_SHRD = 7'b0001000, S_SHWR = 7'b0010000, S_GETW = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   logic [EW-1:0] mem [2][TABLE_DEPTH];
   logic [EW-1:0] rdata_ff;
   logic [CW-1:0] count_ff [2];
   logic [IdW-1:0] next_id_ff;
   state_type st_ff;
   job_type j_ff;
   logic [CW-1:0] idx_ff;
   logic [AW-1:0] raddr;
   logic rd_en, we;
   logic [AW-1:0] waddr;
   logic [EW-1:0] wdata;
   logic [CW-1:0] cnt;
   logic res_v_ff, code_ff;
   logic [103:0] rsp_data_ff;
   logic [IdW-1:0] rid_ff;
   logic [PAYLOAD_BITS-1:0] rpay_ff;
   logic [StatusW-1:0] rst_ff;
   logic [IdW-1:0] rd_id;

   assign cnt = count_ff[j_ff.box];
   assign rd_id = rdata_ff[EW-1 -: IdW];
   assign job_ready = st_ff == S_IDLE;
   assign rsp_tvalid = res_v_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      rd_en = 1'b0;
      raddr = idx_ff[AW-1:0];
      we = 1'b0;
      waddr = idx_ff[AW-1:0];
      wdata = rdata_ff;
      case (st_ff)
         S_SRCH: rd_en = 1'b1;
         S_SHRD: begin
            rd_en = 1'b1;
            raddr = AW'(idx_ff + 1'b1);
         end
         S_SHWR: we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= mem[j_ff.box][raddr];
      if (we) mem[j_ff.box][waddr] <= wdata;
      if (st_ff == S_GETW) begin
         if (j_ff.cmd == CMD_ADD)
            mem[j_ff.box][cnt == CW'(TABLE_DEPTH) ? AW'(cnt - 1'b1) : AW'(cnt)] <=
               {next_id_ff, j_ff.payload[PAYLOAD_BITS-1:0],
                j_ff.box ? j_ff.status : unread_code};
         else if (j_ff.cmd == CMD_MARK)
            mem[0][idx_ff[AW-1:0]] <= {rdata_ff[EW-1:StatusW], read_code};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         count_ff[0] <= '0;
         count_ff[1] <= '0;
         next_id_ff <= 32'd1;
         res_v_ff <= 1'b0;
      end else begin
         if (st_ff == S_DONE && (!res_v_ff || rsp_tready)) res_v_ff <= 1'b1;
         else if (rsp_tready) res_v_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (job_valid) begin
               j_ff <= job;
               idx_ff <= '0;
               code_ff <= 1'b1;
               rid_ff <= '0;
               rpay_ff <= '0;
               rst_ff <= '0;
               case (job.cmd)
                  CMD_ADD: st_ff <= count_ff[job.box] == CW'(TABLE_DEPTH) &&
                     TABLE_DEPTH > 1 ? S_SHRD : S_GETW;
                  CMD_GET: begin
                     idx_ff <= CW'(job.position);
                     st_ff <= S_SRCH;
                  end
                  CMD_MARK, CMD_DEL: st_ff <= S_SRCH;
                  default: st_ff <= S_GETW;
               endcase
            end
            S_SRCH: begin
               if (j_ff.cmd == CMD_GET) begin
                  st_ff <= S_GETW;
                  if ({1'b0, j_ff.position} >= 7'(cnt) ||
                      32'(j_ff.position) >= TABLE_DEPTH) j_ff.cmd <= CMD_BAD;
               end else if (idx_ff >= cnt ||
                            (j_ff.cmd == CMD_MARK && j_ff.box)) begin
                  j_ff.cmd <= CMD_BAD;
                  st_ff <= S_GETW;
               end else st_ff <= S_SCMP;
            end
            S_SCMP: begin
               if (rd_id == j_ff.key) begin
                  code_ff <= 1'b0;
                  st_ff <= j_ff.cmd == CMD_DEL ? S_SHRD : S_GETW;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  st_ff <= S_SRCH;
               end
            end
            S_SHRD: begin
               if (idx_ff + 1'b1 >= cnt) begin
                  count_ff[j_ff.box] <= j_ff.cmd == CMD_ADD ? cnt : cnt - 1'b1;
                  st_ff <= j_ff.cmd == CMD_ADD ? S_GETW : S_DONE;
               end else st_ff <= S_SHWR;
            end
            S_SHWR: begin
               idx_ff <= idx_ff + 1'b1;
               st_ff <= S_SHRD;
            end
            S_GETW: begin
               case (j_ff.cmd)
                  CMD_ADD: begin
                     if (cnt != CW'(TABLE_DEPTH)) count_ff[j_ff.box] <= cnt + 1'b1;
                     rid_ff <= next_id_ff;
                     next_id_ff <= next_id_ff + 1'b1;
                     code_ff <= 1'b0;
                  end
                  CMD_GET: if (!rd_en) begin
                     rid_ff <= rd_id;
                     rpay_ff <= rdata_ff[StatusW +: PAYLOAD_BITS];
                     rst_ff <= rdata_ff[StatusW-1:0];
                     code_ff <= 1'b0;
                  end
                  CMD_CLEAR: begin
                     count_ff[j_ff.box] <= '0;
                     code_ff <= 1'b0;
                  end
                  default: ;
               endcase
               st_ff <= S_DONE;
            end
            S_DONE: if (!res_v_ff || rsp_tready) begin
               rsp_data_ff <= {28'd0, rst_ff, 32'(rpay_ff), rid_ff, 7'(cnt), code_ff};
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: rtl/tagged_message_table_drop_oldest.sv
// Tagged message table top level: request queue, engine and config registers.
// Sequence: an add on a non-full table writes, then responds; a get reads, captures, responds;
// an id search reads and compares each entry visited; a full-table add or a delete shifts entries down.
// Throughput: one request at a time in the engine, set by the single-port table walk.
// Reset: synchronous; counts go to zero, next id to one, unread 0, read 1.
// Table contents are not cleared on reset.
`default_nettype none
`include "tagged_message_table_drop_oldest_macros.svh"
module tagged_message_table_drop_oldest
   import tmt_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int PAYLOAD_BITS = PayloadBitsDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // op[2:0], box[3], payload[35:4], msg_status[39:36], position[45:40], key[77:46]
   input wire logic [79:0] req_tdata,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // result_code[0], entry_count[7:1], entry_id[39:8], entry_payload[71:40],
   // entry_status[75:72]
   output logic [103:0] rsp_tdata,
   input wire logic csr_we,
   input wire logic csr_index,
   input wire logic [StatusW-1:0] csr_wdata
);
   logic [StatusW-1:0] unread_ff, read_ff;
   logic job_valid, job_ready;
   job_type job;

   always_ff @(posedge clock) begin
      if (reset) begin
         unread_ff <= '0;
         read_ff <= 4'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_UNREAD: unread_ff <= csr_wdata;
            CSR_READ: read_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   tmt_front #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_front (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_op(req_tdata[2:0]), .req_box(req_tdata[3]), .req_payload(req_tdata[35:4]),
      .req_status(req_tdata[39:36]), .req_position(req_tdata[45:40]),
      .req_key(req_tdata[77:46]), .job_valid, .job_ready, .job
   );

   tmt_engine #(.TABLE_DEPTH(TABLE_DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)) u_engine (
      .clock, .reset, .job_valid, .job_ready, .job,
      .unread_code(unread_ff), .read_code(read_ff),
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   `TMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response dropped while stalled")
   `TMT_ASSERT_IMPL(a_count_range, clock, reset, rsp_tvalid, rsp_tdata[7:1] <= 7'(TABLE_DEPTH), "count above depth")
   `TMT_ASSERT_IMPL(a_fail_zero, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[75:8] == '0, "failed result carries data")
endmodule
`default_nettype wire
